@@ rtl/dbss_pkg.sv @@
// shared constants, types and codes of the deadline batch-shrink scheduler
`timescale 1ns / 1ps

package dbss_pkg;

    // set capacity and derived count widths
    localparam int MAX_TASKS = 4096;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int NUM_BATCH = 4;
    localparam int BATCH_W   = 2;
    localparam int TOT_W     = CNT_W + 2;
    localparam int TERM_W    = $clog2(NUM_BATCH + 1);

    // field widths
    localparam int SIZE_W     = 3;
    localparam int TAG_W      = 16;
    localparam int DL_W       = 24;
    localparam int KIND_W     = 2;
    localparam int TIME_W     = 32;
    localparam int SLOPE_W    = 16;
    localparam int OVH_W      = 20;
    localparam int MAP_W      = 9;
    localparam int FLD_W      = 3;
    localparam int PROD_W     = SLOPE_W + CNT_W;
    localparam int ACC_RAW_W  = PROD_W + 3;
    localparam int ACC_W      = (ACC_RAW_W > TIME_W + 1) ? ACC_RAW_W : TIME_W + 1;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOPE_ONE   = 3'd0,
        CFG_SLOPE_TWO   = 3'd1,
        CFG_SLOPE_THREE = 3'd2,
        CFG_SLOPE_FOUR  = 3'd3,
        CFG_OVERHEAD    = 3'd4,
        CFG_SHRINK_MAP  = 3'd5
    } cfg_index_t;

    // register reset values
    localparam logic [SLOPE_W-1:0] SLOPE_ONE_RST   = 16'd102;
    localparam logic [SLOPE_W-1:0] SLOPE_TWO_RST   = 16'd205;
    localparam logic [SLOPE_W-1:0] SLOPE_THREE_RST = 16'd307;
    localparam logic [SLOPE_W-1:0] SLOPE_FOUR_RST  = 16'd410;
    localparam logic [OVH_W-1:0]   OVERHEAD_RST    = 20'd451;
    localparam logic [MAP_W-1:0]   SHRINK_MAP_RST  = 9'd428;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_PLACED  = 2'd0,
        KIND_MOVED   = 2'd1,
        KIND_SKIPPED = 2'd2,
        KIND_GAVE_UP = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic [NUM_BATCH-1:0][SLOPE_W-1:0] slope;
        logic [OVH_W-1:0]                  overhead;
        logic [MAP_W-1:0]                  shrink_map;
    } cfg_regs_t;

    typedef logic [NUM_BATCH-1:0][CNT_W-1:0] count_vec_t;

    // estimator status toward the controller
    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] time_est;
    } est_stat_t;

endpackage

@@ rtl/dbss_ifs.sv @@
// channel interfaces: task input, event output and configuration writes
`timescale 1ns / 1ps

interface dbss_task_if;
    import dbss_pkg::*;

    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] task_size;
    logic [TAG_W-1:0]  task_tag;
    logic [DL_W-1:0]   task_deadline;
    logic              first_task;

    modport source (output valid, task_size, task_tag, task_deadline, first_task,
                    input ready);
    modport sink   (input valid, task_size, task_tag, task_deadline, first_task,
                    output ready);
endinterface

interface dbss_event_if;
    import dbss_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  event_kind;
    logic [TAG_W-1:0]   event_tag;
    logic [BATCH_W-1:0] from_batch;
    logic [BATCH_W-1:0] to_batch;
    logic [CNT_W-1:0]   moved_count;
    logic [TIME_W-1:0]  total_time;
    logic               last;

    modport source (output valid, event_kind, event_tag, from_batch, to_batch,
                    moved_count, total_time, last,
                    input ready);
    modport sink   (input valid, event_kind, event_tag, from_batch, to_batch,
                    moved_count, total_time, last,
                    output ready);
endinterface

interface dbss_cfg_if;
    import dbss_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/deadline_batch_shrink_scheduler.sv @@
// top level of the deadline batch-shrink scheduler
//
//  channel    dir  transaction
//  task_in    in   one image task: size, tag, deadline, first-of-set flag
//  event_out  out  one event: kind, tag, batches, moved count, time, last flag
//  cfg        in   one register write: index and data, never stalled
//
// a placed task runs an estimate and its event; the scan then steps through each
// field from the top batch down, and each move runs another estimate and event; a
// scan with no settling move ends in a gave-up event; each estimate runs four
// multiply-accumulate passes through the one shared multiplier
// task_in is ready only between tasks; the result register lets the next task
// start while the last event of the previous one waits on event_out
// reset loads the register defaults and clears counts, deadline and halt
`timescale 1ns / 1ps

module deadline_batch_shrink_scheduler (
    input  logic         clk,
    input  logic         rst_n,
    dbss_task_if.sink    task_in,
    dbss_event_if.source event_out,
    dbss_cfg_if.sink     cfg
);
    import dbss_pkg::*;

    cfg_regs_t  cfg_regs;
    count_vec_t resident;
    est_stat_t  est_stat;
    logic       est_start;

    // configuration registers
    dbss_cfg u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_in (cfg),
        .regs   (cfg_regs)
    );

    // shared time estimator
    dbss_est u_est (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (est_start),
        .cfg      (cfg_regs),
        .resident (resident),
        .stat     (est_stat)
    );

    // sequencer and result register
    dbss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .task_in   (task_in),
        .event_out (event_out),
        .cfg       (cfg_regs),
        .est_start (est_start),
        .resident  (resident),
        .est       (est_stat)
    );

endmodule

@@ rtl/dbss_cfg.sv @@
// configuration register file: batch slopes, fixed overhead and shrink map
`timescale 1ns / 1ps

module dbss_cfg (
    input  logic                clk,
    input  logic                rst_n,
    dbss_cfg_if.sink            cfg_in,
    output dbss_pkg::cfg_regs_t regs
);
    import dbss_pkg::*;

    cfg_regs_t regs_reg;

    // writes never stall
    assign cfg_in.ready = 1'b1;
    assign regs         = regs_reg;

    // register write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.slope[0]   <= SLOPE_ONE_RST;
            regs_reg.slope[1]   <= SLOPE_TWO_RST;
            regs_reg.slope[2]   <= SLOPE_THREE_RST;
            regs_reg.slope[3]   <= SLOPE_FOUR_RST;
            regs_reg.overhead   <= OVERHEAD_RST;
            regs_reg.shrink_map <= SHRINK_MAP_RST;
        end
        else if (cfg_in.valid)
        begin
            unique case (cfg_index_t'(cfg_in.index))
                CFG_SLOPE_ONE:   regs_reg.slope[0]   <= cfg_in.data[SLOPE_W-1:0];
                CFG_SLOPE_TWO:   regs_reg.slope[1]   <= cfg_in.data[SLOPE_W-1:0];
                CFG_SLOPE_THREE: regs_reg.slope[2]   <= cfg_in.data[SLOPE_W-1:0];
                CFG_SLOPE_FOUR:  regs_reg.slope[3]   <= cfg_in.data[SLOPE_W-1:0];
                CFG_OVERHEAD:    regs_reg.overhead   <= cfg_in.data[OVH_W-1:0];
                CFG_SHRINK_MAP:  regs_reg.shrink_map <= cfg_in.data[MAP_W-1:0];
                default:         ;
            endcase
        end
    end

endmodule

@@ rtl/dbss_est.sv @@
// time estimator: one shared multiplier accumulates slope times resident count
`timescale 1ns / 1ps

module dbss_est (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  dbss_pkg::cfg_regs_t  cfg,
    input  dbss_pkg::count_vec_t resident,
    output dbss_pkg::est_stat_t  stat
);
    import dbss_pkg::*;

    logic              busy_reg;
    logic              pvalid_reg;
    logic              done_reg;
    logic [TERM_W-1:0] term_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic              term_live;
    logic [BATCH_W-1:0] term_idx;

    assign term_live = (term_reg < TERM_W'(NUM_BATCH));
    assign term_idx  = term_reg[BATCH_W-1:0];

    // sequencing over the four batch terms
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            pvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
            term_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg   <= 1'b1;
                pvalid_reg <= 1'b0;
                term_reg   <= '0;
            end
            else if (busy_reg)
            begin
                pvalid_reg <= term_live;
                if (term_live)
                begin
                    term_reg <= term_reg + 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // multiply, then accumulate the registered product
    always_ff @(posedge clk)
    begin
        if (busy_reg && term_live)
        begin
            prod_reg <= PROD_W'(cfg.slope[term_idx]) * PROD_W'(resident[term_idx]);
        end
        if (start)
        begin
            acc_reg <= ACC_W'(cfg.overhead);
        end
        else if (busy_reg && pvalid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // saturate to the result width
    assign stat.done     = done_reg;
    assign stat.time_est = (|acc_reg[ACC_W-1:TIME_W]) ? {TIME_W{1'b1}} : acc_reg[TIME_W-1:0];

endmodule

@@ rtl/dbss_ctrl.sv @@
// sequencer: batch counts, placement, shrink scan and result register
`timescale 1ns / 1ps

module dbss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    dbss_task_if.sink            task_in,
    dbss_event_if.source         event_out,
    input  dbss_pkg::cfg_regs_t  cfg,
    output logic                 est_start,
    output dbss_pkg::count_vec_t resident,
    input  dbss_pkg::est_stat_t  est
);
    import dbss_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECIDE = 5'b00010,
        ST_EST    = 5'b00100,
        ST_EMIT   = 5'b01000,
        ST_SCAN   = 5'b10000
    } state_t;

    state_t             state_reg;
    count_vec_t         native_reg;
    count_vec_t         resident_reg;
    logic [DL_W-1:0]    deadline_reg;
    logic               halted_reg;
    logic               est_start_reg;
    logic [BATCH_W-1:0] bi_reg;

    // current task and event under construction
    logic [SIZE_W-1:0]  size_reg;
    logic [TAG_W-1:0]   tag_reg;
    event_kind_t        kind_reg;
    logic [BATCH_W-1:0] from_reg;
    logic [BATCH_W-1:0] to_reg;
    logic [CNT_W-1:0]   mcnt_reg;
    logic [TIME_W-1:0]  time_reg;

    // output register
    logic               out_valid_reg;
    event_kind_t        out_kind_reg;
    logic [TAG_W-1:0]   out_tag_reg;
    logic [BATCH_W-1:0] out_from_reg;
    logic [BATCH_W-1:0] out_to_reg;
    logic [CNT_W-1:0]   out_cnt_reg;
    logic [TIME_W-1:0]  out_time_reg;
    logic               out_last_reg;

    logic [TOT_W-1:0]              total;
    logic                          bad_task;
    logic [BATCH_W-1:0]            place_b;
    logic [NUM_BATCH-1:0][FLD_W-1:0] map_vec;
    logic [FLD_W-1:0]              field;
    logic [BATCH_W-1:0]            tgt;
    logic [CNT_W-1:0]              cnt_sel;
    logic                          no_move;
    logic [TIME_W-1:0]             dl_ext;
    logic                          emit_last;
    logic                          slot_free;

    assign task_in.ready = (state_reg == ST_IDLE);
    assign est_start     = est_start_reg;
    assign resident      = resident_reg;

    assign event_out.valid       = out_valid_reg;
    assign event_out.event_kind  = out_kind_reg;
    assign event_out.event_tag   = out_tag_reg;
    assign event_out.from_batch  = out_from_reg;
    assign event_out.to_batch    = out_to_reg;
    assign event_out.moved_count = out_cnt_reg;
    assign event_out.total_time  = out_time_reg;
    assign event_out.last        = out_last_reg;

    // set occupancy and size check
    assign total = TOT_W'(resident_reg[0]) + TOT_W'(resident_reg[1])
                 + TOT_W'(resident_reg[2]) + TOT_W'(resident_reg[3]);
    assign bad_task = (size_reg == '0) || (size_reg > SIZE_W'(NUM_BATCH))
                    || (total >= TOT_W'(MAX_TASKS));
    assign place_b  = BATCH_W'(size_reg - 1'b1);

    // shrink field of the batch under scan; batch zero never shrinks
    assign map_vec = {cfg.shrink_map, {FLD_W{1'b0}}};
    assign field   = map_vec[bi_reg];
    assign tgt     = field[BATCH_W-1:0];
    assign cnt_sel = native_reg[bi_reg];
    assign no_move = (cnt_sel == '0) || !field[FLD_W-1] || (tgt == bi_reg);

    // whether this event closes the task
    assign dl_ext = TIME_W'(deadline_reg);
    always_comb
    begin
        case (kind_reg)
            KIND_PLACED: emit_last = !(time_reg > dl_ext);
            KIND_MOVED:  emit_last = (time_reg < dl_ext);
            default:     emit_last = 1'b1;
        endcase
    end

    assign slot_free = !out_valid_reg || event_out.ready;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            native_reg    <= '0;
            resident_reg  <= '0;
            deadline_reg  <= '0;
            halted_reg    <= 1'b0;
            est_start_reg <= 1'b0;
            bi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            est_start_reg <= 1'b0;
            // the emit state drives the valid flag itself while it loads
            if (event_out.ready && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (task_in.valid)
                    begin
                        if (task_in.first_task)
                        begin
                            native_reg   <= '0;
                            resident_reg <= '0;
                            deadline_reg <= task_in.task_deadline;
                            halted_reg   <= 1'b0;
                        end
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    if (!halted_reg && !bad_task)
                    begin
                        native_reg[place_b]   <= native_reg[place_b] + 1'b1;
                        resident_reg[place_b] <= resident_reg[place_b] + 1'b1;
                    end
                    est_start_reg <= 1'b1;
                    state_reg     <= ST_EST;
                end
                ST_EST:
                begin
                    if (est.done)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (kind_reg == KIND_PLACED)
                        begin
                            bi_reg <= BATCH_W'(NUM_BATCH - 1);
                        end
                        state_reg <= emit_last ? ST_IDLE : ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (bi_reg == '0)
                    begin
                        halted_reg <= 1'b1;
                        state_reg  <= ST_EMIT;
                    end
                    else if (no_move)
                    begin
                        bi_reg <= bi_reg - 1'b1;
                    end
                    else
                    begin
                        native_reg[bi_reg]   <= '0;
                        resident_reg[bi_reg] <= resident_reg[bi_reg] - cnt_sel;
                        resident_reg[tgt]    <= resident_reg[tgt] + cnt_sel;
                        bi_reg               <= bi_reg - 1'b1;
                        est_start_reg        <= 1'b1;
                        state_reg            <= ST_EST;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // task and event payload
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (task_in.valid)
                begin
                    size_reg <= task_in.task_size;
                    tag_reg  <= task_in.task_tag;
                end
            end
            ST_DECIDE:
            begin
                mcnt_reg <= '0;
                if (halted_reg)
                begin
                    kind_reg <= KIND_GAVE_UP;
                    from_reg <= '0;
                    to_reg   <= '0;
                end
                else if (bad_task)
                begin
                    kind_reg <= KIND_SKIPPED;
                    from_reg <= '0;
                    to_reg   <= '0;
                end
                else
                begin
                    kind_reg <= KIND_PLACED;
                    from_reg <= place_b;
                    to_reg   <= place_b;
                end
            end
            ST_EST:
            begin
                if (est.done)
                begin
                    time_reg <= est.time_est;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_kind_reg <= kind_reg;
                    out_tag_reg  <= tag_reg;
                    out_from_reg <= from_reg;
                    out_to_reg   <= to_reg;
                    out_cnt_reg  <= mcnt_reg;
                    out_time_reg <= time_reg;
                    out_last_reg <= emit_last;
                end
            end
            ST_SCAN:
            begin
                if (bi_reg == '0)
                begin
                    kind_reg <= KIND_GAVE_UP;
                    from_reg <= '0;
                    to_reg   <= '0;
                    mcnt_reg <= '0;
                end
                else if (!no_move)
                begin
                    kind_reg <= KIND_MOVED;
                    from_reg <= bi_reg;
                    to_reg   <= tgt;
                    mcnt_reg <= cnt_sel;
                end
            end
            default: ;
        endcase
    end

    // moved tasks leave only the native part of a batch
    assert property (@(posedge clk) disable iff (!rst_n)
        (native_reg[0] <= resident_reg[0]) && (native_reg[1] <= resident_reg[1])
        && (native_reg[2] <= resident_reg[2]) && (native_reg[3] <= resident_reg[3]))
        else $error("native count exceeds resident count");

    // the set never grows past its capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        total <= TOT_W'(MAX_TASKS))
        else $error("set holds more tasks than its capacity");

    // an exhausted scan halts and reports gave up next
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && (bi_reg == '0)
        |=> (state_reg == ST_EMIT) && (kind_reg == KIND_GAVE_UP) && halted_reg)
        else $error("exhausted shrink scan did not halt");

    // estimates complete only while one is awaited
    assert property (@(posedge clk) disable iff (!rst_n)
        est.done |-> (state_reg == ST_EST))
        else $error("estimate finished outside the wait state");

endmodule

@@ test/testbench.sv @@
// testbench of the deadline batch-shrink scheduler: directed and random task sets against a predictor
`timescale 1ns / 1ps

module testbench;
    import dbss_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_LEN   = 400;
    localparam int MAX_SHOWN  = 10;
    localparam int PHASE_SIZE = 40;

    typedef struct packed {
        logic [SIZE_W-1:0] size_cls;
        logic [TAG_W-1:0]  tag;
        logic [DL_W-1:0]   deadline;
        logic              first;
    } task_item_t;

    typedef struct packed {
        event_kind_t        kind;
        logic [TAG_W-1:0]   tag;
        logic [BATCH_W-1:0] from_b;
        logic [BATCH_W-1:0] to_b;
        logic [CNT_W-1:0]   count;
        logic [TIME_W-1:0]  total;
        logic               last;
    } sched_event_t;

    logic clk;
    logic rst_n;

    dbss_task_if  task_bus ();
    dbss_event_if event_bus ();
    dbss_cfg_if   cfg_bus ();

    deadline_batch_shrink_scheduler i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .task_in   (task_bus),
        .event_out (event_bus),
        .cfg       (cfg_bus)
    );

    // stimulus and expected results
    task_item_t   pending_tasks[$];
    sched_event_t expected_events[$];

    int unsigned tasks_queued   = 0;
    int unsigned tasks_accepted = 0;
    int unsigned events_checked = 0;
    int unsigned mismatches     = 0;
    int unsigned cfg_writes     = 0;
    int unsigned cfg_settings   = 0;
    int unsigned kind_seen[4]   = '{0, 0, 0, 0};
    int unsigned idle_cycles;
    int unsigned src_idle_pct   = 0;
    int unsigned snk_stall_pct  = 0;
    int unsigned hold_asked     = 0;
    int unsigned hold_served;
    int unsigned hold_left;
    logic        task_taken;
    logic        cfg_taken;

    // predictor copy of registers and scheduler state
    logic [SLOPE_W-1:0] slope_reg [NUM_BATCH];
    logic [OVH_W-1:0]   overhead_reg;
    logic [MAP_W-1:0]   map_reg;
    logic [CNT_W-1:0]   native_cnt [NUM_BATCH];
    logic [CNT_W-1:0]   resident_cnt [NUM_BATCH];
    logic [DL_W-1:0]    set_deadline;
    bit                 halted_q;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // estimated set time, saturating at the result width
    function automatic logic [TIME_W-1:0] estimate_time();
        longint unsigned acc;
        int b;
        acc = longint'(overhead_reg);
        for (b = 0; b < NUM_BATCH; b++)
            acc += longint'(slope_reg[b]) * longint'(resident_cnt[b]);
        return (acc > 64'hFFFF_FFFF) ? '1 : acc[TIME_W-1:0];
    endfunction

    function automatic sched_event_t make_event(input event_kind_t k,
                                                input logic [TAG_W-1:0] tg,
                                                input logic [BATCH_W-1:0] fb,
                                                input logic [BATCH_W-1:0] tb,
                                                input logic [CNT_W-1:0] n,
                                                input logic [TIME_W-1:0] tm);
        sched_event_t e;
        e.kind   = k;
        e.tag    = tg;
        e.from_b = fb;
        e.to_b   = tb;
        e.count  = n;
        e.total  = tm;
        e.last   = 1'b0;
        return e;
    endfunction

    // place one task, shrink batches while over the deadline, queue the events it causes
    function automatic void schedule_task(input task_item_t item);
        sched_event_t       burst[$];
        sched_event_t       e;
        logic [BATCH_W-1:0] b;
        logic [BATCH_W-1:0] tgt;
        logic [FLD_W-1:0]   fld;
        logic [CNT_W-1:0]   moving;
        logic [TIME_W-1:0]  tm;
        int unsigned        occupied;
        bit                 settled;
        int                 i;

        // a new set clears counts and halt and latches the deadline
        if (item.first)
        begin
            for (i = 0; i < NUM_BATCH; i++)
            begin
                native_cnt[i]   = '0;
                resident_cnt[i] = '0;
            end
            set_deadline = item.deadline;
            halted_q     = 1'b0;
        end

        occupied = 0;
        for (i = 0; i < NUM_BATCH; i++)
            occupied += resident_cnt[i];

        if (halted_q)
            burst.push_back(make_event(KIND_GAVE_UP, item.tag, '0, '0, '0, estimate_time()));
        else if (item.size_cls == 3'd0 || item.size_cls > 3'd4 || occupied >= MAX_TASKS)
            burst.push_back(make_event(KIND_SKIPPED, item.tag, '0, '0, '0, estimate_time()));
        else
        begin
            b = BATCH_W'(item.size_cls - 3'd1);
            native_cnt[b]++;
            resident_cnt[b]++;
            tm = estimate_time();
            burst.push_back(make_event(KIND_PLACED, item.tag, b, b, '0, tm));

            // shrink native groups from the largest batch down
            if (tm > set_deadline)
            begin
                settled = 1'b0;
                for (i = 3; i >= 1 && !settled; i--)
                begin
                    fld    = map_reg[FLD_W*(i-1) +: FLD_W];
                    tgt    = fld[1:0];
                    moving = native_cnt[i];
                    if (moving != 0 && fld[2] && tgt != i)
                    begin
                        native_cnt[i]     = '0;
                        resident_cnt[i]   = resident_cnt[i] - moving;
                        resident_cnt[tgt] = resident_cnt[tgt] + moving;
                        tm = estimate_time();
                        burst.push_back(make_event(KIND_MOVED, item.tag, BATCH_W'(i), tgt,
                                                   moving, tm));
                        if (tm < set_deadline)
                            settled = 1'b1;
                    end
                end
                if (!settled)
                begin
                    halted_q = 1'b1;
                    burst.push_back(make_event(KIND_GAVE_UP, item.tag, '0, '0, '0, tm));
                end
            end
        end

        e = burst.pop_back();
        e.last = 1'b1;
        burst.push_back(e);
        foreach (burst[j])
            expected_events.push_back(burst[j]);
    endfunction

    function automatic void report_mismatch(input string what, input sched_event_t got,
                                            input sched_event_t want);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
        begin
            $display("%0t: %s: got kind %0d tag %h from %0d to %0d count %0d time %0d last %0b",
                     $realtime, what, got.kind, got.tag, got.from_b, got.to_b, got.count,
                     got.total, got.last);
            $display("%0t:   wanted kind %0d tag %h from %0d to %0d count %0d time %0d last %0b",
                     $realtime, want.kind, want.tag, want.from_b, want.to_b, want.count,
                     want.total, want.last);
        end
    endfunction

    // monitor: predictor updates, result checks and watchdog
    always @(posedge clk or negedge rst_n)
    begin
        sched_event_t seen;
        sched_event_t want;
        int b;
        if (!rst_n)
        begin
            task_taken   <= 1'b0;
            cfg_taken    <= 1'b0;
            idle_cycles  <= 0;
            slope_reg[0] = SLOPE_ONE_RST;
            slope_reg[1] = SLOPE_TWO_RST;
            slope_reg[2] = SLOPE_THREE_RST;
            slope_reg[3] = SLOPE_FOUR_RST;
            overhead_reg = OVERHEAD_RST;
            map_reg      = SHRINK_MAP_RST;
            for (b = 0; b < NUM_BATCH; b++)
            begin
                native_cnt[b]   = '0;
                resident_cnt[b] = '0;
            end
            set_deadline = '0;
            halted_q     = 1'b0;
        end
        else
        begin
            task_taken <= task_bus.valid && task_bus.ready;
            cfg_taken  <= cfg_bus.valid && cfg_bus.ready;

            // register write transaction
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                case (cfg_index_t'(cfg_bus.index))
                    CFG_SLOPE_ONE:   slope_reg[0] = cfg_bus.data[SLOPE_W-1:0];
                    CFG_SLOPE_TWO:   slope_reg[1] = cfg_bus.data[SLOPE_W-1:0];
                    CFG_SLOPE_THREE: slope_reg[2] = cfg_bus.data[SLOPE_W-1:0];
                    CFG_SLOPE_FOUR:  slope_reg[3] = cfg_bus.data[SLOPE_W-1:0];
                    CFG_OVERHEAD:    overhead_reg = cfg_bus.data[OVH_W-1:0];
                    CFG_SHRINK_MAP:  map_reg      = cfg_bus.data[MAP_W-1:0];
                    default: ;
                endcase
            end

            // task transaction
            if (task_bus.valid && task_bus.ready)
            begin
                schedule_task('{size_cls: task_bus.task_size, tag: task_bus.task_tag,
                                deadline: task_bus.task_deadline, first: task_bus.first_task});
                tasks_accepted++;
            end

            // event transaction
            if (event_bus.valid && event_bus.ready)
            begin
                seen.kind   = event_kind_t'(event_bus.event_kind);
                seen.tag    = event_bus.event_tag;
                seen.from_b = event_bus.from_batch;
                seen.to_b   = event_bus.to_batch;
                seen.count  = event_bus.moved_count;
                seen.total  = event_bus.total_time;
                seen.last   = event_bus.last;
                events_checked++;
                kind_seen[int'(seen.kind)]++;
                if (expected_events.size() == 0)
                    report_mismatch("unexpected event", seen, '0);
                else
                begin
                    want = expected_events.pop_front();
                    if (seen !== want)
                        report_mismatch("event mismatch", seen, want);
                end
            end

            // watchdog on cycles with no transaction anywhere
            if ((task_bus.valid && task_bus.ready) || (event_bus.valid && event_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles, %0d events still expected",
                         $realtime, IDLE_LIMIT, expected_events.size());
                $display("end of test: mismatches");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // task driver
    always @(negedge clk or negedge rst_n)
    begin
        task_item_t next_item;
        if (!rst_n)
        begin
            task_bus.valid         <= 1'b0;
            task_bus.task_size     <= '0;
            task_bus.task_tag      <= '0;
            task_bus.task_deadline <= '0;
            task_bus.first_task    <= 1'b0;
        end
        else if (!task_bus.valid || task_taken)
        begin
            if (pending_tasks.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                next_item = pending_tasks.pop_front();
                task_bus.valid         <= 1'b1;
                task_bus.task_size     <= next_item.size_cls;
                task_bus.task_tag      <= next_item.tag;
                task_bus.task_deadline <= next_item.deadline;
                task_bus.first_task    <= next_item.first;
            end
            else
                task_bus.valid <= 1'b0;
        end
    end

    // event receiver with random stalls and long hold-offs on request
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_bus.ready <= 1'b0;
            hold_left       <= 0;
            hold_served     <= 0;
        end
        else if (hold_left != 0)
        begin
            event_bus.ready <= 1'b0;
            hold_left       <= hold_left - 1;
        end
        else if (hold_served != hold_asked)
        begin
            event_bus.ready <= 1'b0;
            hold_left       <= HOLD_LEN;
            hold_served     <= hold_asked;
        end
        else
            event_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    function automatic void push_task(input logic [SIZE_W-1:0] sz, input logic [TAG_W-1:0] tg,
                                      input logic [DL_W-1:0] dl, input logic fst);
        pending_tasks.push_back('{size_cls: sz, tag: tg, deadline: dl, first: fst});
        tasks_queued++;
    endfunction

    // one task set: a first task with a deadline near the reachable times, then placements
    function automatic void queue_random_set(input int unsigned n);
        longint unsigned span;
        longint unsigned dl;
        int unsigned     k;
        span = (longint'(slope_reg[0]) + slope_reg[1] + slope_reg[2] + slope_reg[3]) * n / 4 + 1;
        case ($urandom_range(9))
            0:       dl = 0;
            1:       dl = 24'hFF_FFFF;
            2:       dl = $urandom_range(24'hFF_FFFF);
            default: dl = longint'(overhead_reg) + longint'($urandom) % span;
        endcase
        if (dl > 24'hFF_FFFF)
            dl = 24'hFF_FFFF;
        for (k = 0; k < n; k++)
        begin
            // occasional noise: bad sizes and stray set starts
            if (k != 0 && $urandom_range(11) == 0)
                push_task(SIZE_W'($urandom_range(7)), TAG_W'($urandom), DL_W'($urandom),
                          $urandom_range(3) == 0);
            else
                push_task(SIZE_W'($urandom_range(1, 4)), TAG_W'($urandom),
                          (k == 0) ? dl[DL_W-1:0] : DL_W'($urandom), k == 0);
        end
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_slope();
        return ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(65535))
                                        : CFG_DATA_W'($urandom_range(600));
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(negedge clk);
        while (!cfg_taken)
            @(negedge clk);
        cfg_bus.valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] s1, input logic [CFG_DATA_W-1:0] s2,
                             input logic [CFG_DATA_W-1:0] s3, input logic [CFG_DATA_W-1:0] s4,
                             input logic [CFG_DATA_W-1:0] ovh, input logic [CFG_DATA_W-1:0] smap);
        write_reg(CFG_SLOPE_ONE, s1);
        write_reg(CFG_SLOPE_TWO, s2);
        write_reg(CFG_SLOPE_THREE, s3);
        write_reg(CFG_SLOPE_FOUR, s4);
        write_reg(CFG_OVERHEAD, ovh);
        write_reg(CFG_SHRINK_MAP, smap);
        cfg_settings++;
    endtask

    // wait until every task is taken and every event has come back
    task automatic wait_idle();
        wait (tasks_accepted == tasks_queued && expected_events.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    // main sequence
    initial
    begin
        int p;
        int k;
        int unsigned phase_start;

        rst_n         = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = CFG_SLOPE_ONE;
        cfg_bus.data  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed sets under the reset register values
        push_task(3'd0, 16'h0000, 24'd5000, 1'b1);
        push_task(3'd5, 16'hFFFF, 24'd0, 1'b0);
        push_task(3'd6, 16'h1234, 24'd0, 1'b0);
        push_task(3'd7, 16'h8001, 24'd0, 1'b0);
        push_task(3'd1, 16'h0001, 24'd0, 1'b0);
        push_task(3'd2, 16'h0002, 24'd0, 1'b0);
        push_task(3'd3, 16'h0003, 24'd0, 1'b0);
        push_task(3'd4, 16'h0004, 24'd0, 1'b0);
        // zero deadline: no move can settle the set, then the halted block drops tasks
        push_task(3'd1, 16'h0010, 24'd0, 1'b1);
        push_task(3'd2, 16'h0011, 24'd0, 1'b0);
        push_task(3'd0, 16'h0012, 24'd0, 1'b0);
        // time equal to the deadline does not shrink
        push_task(3'd4, 16'h0020, 24'd861, 1'b1);
        push_task(3'd4, 16'h0021, 24'd0, 1'b0);
        // every batch above the first shrinks and the set still gives up
        push_task(3'd2, 16'h0030, 24'd963, 1'b1);
        push_task(3'd3, 16'h0031, 24'd0, 1'b0);
        push_task(3'd4, 16'h0032, 24'd0, 1'b0);
        // equal time while shrinking keeps going, then a move settles it
        push_task(3'd2, 16'h0040, 24'd1270, 1'b1);
        push_task(3'd3, 16'h0041, 24'd0, 1'b0);
        push_task(3'd4, 16'h0042, 24'd0, 1'b0);
        push_task(3'd4, 16'hFFFF, 24'hFF_FFFF, 1'b1);
        push_task(3'd1, 16'hA5A5, 24'h5A_5A5A, 1'b0);
        wait_idle();

        // register extremes: all maximal (targets above and equal), then all zero (disabled)
        configure(20'h0_FFFF, 20'h0_FFFF, 20'h0_FFFF, 20'h0_FFFF, 20'hF_FFFF, 20'h0_01FF);
        for (k = 0; k < 4; k++)
            queue_random_set($urandom_range(2, 8));
        wait_idle();
        configure('0, '0, '0, '0, '0, '0);
        for (k = 0; k < 3; k++)
            queue_random_set($urandom_range(2, 8));
        wait_idle();

        // random phases, one per idling mode, each paused halfway until drained
        for (p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1:       begin src_idle_pct = 79; snk_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  snk_stall_pct = 79; end
                default: begin src_idle_pct = 27; snk_stall_pct = 27; end
            endcase
            configure(rand_slope(), rand_slope(), rand_slope(), rand_slope(),
                      ($urandom_range(7) == 0) ? 20'hF_FFFF
                                               : CFG_DATA_W'($urandom_range(20000)),
                      CFG_DATA_W'($urandom_range(511)));
            phase_start = tasks_queued;
            while (tasks_queued - phase_start < PHASE_SIZE / 2)
                queue_random_set($urandom_range(2, 10));
            // receiver holds off while tasks keep coming
            if (p == 0)
                hold_asked++;
            wait_idle();
            while (tasks_queued - phase_start < PHASE_SIZE)
                queue_random_set($urandom_range(2, 10));
            wait_idle();
        end

        repeat (50) @(posedge clk);

        $display("covered %0d tasks and %0d events: %0d placed, %0d moved, %0d skipped, %0d gave up",
                 tasks_accepted, events_checked, kind_seen[0], kind_seen[1], kind_seen[2],
                 kind_seen[3]);
        $display("with %0d register writes over %0d settings and four idling modes",
                 cfg_writes, cfg_settings);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
